>>> design/nacp_pkg.sv
// Shared types and constants for the network address command parser.
`timescale 1ns / 1ps

package nacp_pkg;

  // One received command-line byte.
  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } in_t;

  // One parse result, produced on the last byte of a line.
  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] address_value;
  } out_t;

  // Result status codes.
  localparam logic [3:0] StIpSet     = 4'd0;
  localparam logic [3:0] StMaskSet   = 4'd1;
  localparam logic [3:0] StGwSet     = 4'd2;
  localparam logic [3:0] StMacValid  = 4'd3;
  localparam logic [3:0] StHelp      = 4'd4;
  localparam logic [3:0] StPrint     = 4'd5;
  localparam logic [3:0] StSyntaxErr = 4'd6;
  localparam logic [3:0] StUnknown   = 4'd7;
  localparam logic [3:0] StNoDash    = 4'd8;

  // ASCII characters of interest.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChM     = 8'h6D;

  // Address window lengths after the space, in bytes.
  localparam logic [5:0] IpWindow  = 6'd19;
  localparam logic [5:0] MacWindow = 6'd29;

  // Bytes checked per token.
  localparam logic [1:0] IpTokLimit  = 2'd3;
  localparam logic [1:0] MacTokLimit = 2'd2;

  // Expected token counts.
  localparam logic [2:0] IpTokens  = 3'd4;
  localparam logic [2:0] MacTokens = 3'd6;
  localparam logic [2:0] TokSat    = 3'd7;

endpackage

>>> design/nacp_parse.sv
// Per-character line parser: line state registers and result decode.
`timescale 1ns / 1ps

module nacp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  nacp_pkg::in_t item_i,
  output logic          res_valid_o,
  output nacp_pkg::out_t res_o
);

  typedef enum logic [2:0] {
    PhSearch,
    PhLetter,
    PhSpace,
    PhWindow,
    PhClosed,
    PhDecided,
    PhNoDash
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  letter_q, letter_d;
  logic [5:0]  win_q, win_d;
  logic [2:0]  tok_q, tok_d;
  logic [1:0]  tcc_q, tcc_d;
  logic [9:0]  acc_q, acc_d;
  logic        fault_q, fault_d;
  logic [7:0]  tb_q [4];
  logic [7:0]  tb_d [4];

  logic [7:0]  c;
  logic        is_mac, is_dec, is_hex, is_addr;
  logic [7:0]  delim;
  logic [1:0]  lim;
  logic [5:0]  win_lim;
  logic [9:0]  acc_base;
  logic [3:0]  st;
  logic [31:0] val;

  assign c       = item_i.character;
  assign is_mac  = (letter_q == nacp_pkg::ChM);
  assign is_dec  = (c >= nacp_pkg::Ch0) && (c <= nacp_pkg::Ch9);
  assign is_hex  = is_dec || ((c >= nacp_pkg::ChUpA) && (c <= nacp_pkg::ChUpF));
  assign is_addr = (c == nacp_pkg::ChI) || (c == nacp_pkg::ChS) ||
                   (c == nacp_pkg::ChG) || (c == nacp_pkg::ChM);
  assign delim   = is_mac ? nacp_pkg::ChColon : nacp_pkg::ChDot;
  assign lim     = is_mac ? nacp_pkg::MacTokLimit : nacp_pkg::IpTokLimit;
  assign win_lim = is_mac ? nacp_pkg::MacWindow : nacp_pkg::IpWindow;

  // Next line state for the incoming byte.
  always_comb begin
    phase_d  = phase_q;
    letter_d = letter_q;
    win_d    = win_q;
    tok_d    = tok_q;
    tcc_d    = tcc_q;
    acc_d    = acc_q;
    fault_d  = fault_q;
    acc_base = acc_q;
    for (int k = 0; k < 4; k++) begin
      tb_d[k] = tb_q[k];
    end
    case (phase_q)
      PhSearch: begin
        if (c == nacp_pkg::ChDash) begin
          phase_d = PhLetter;
        end else if (c == nacp_pkg::ChNul) begin
          phase_d = PhNoDash;
        end
      end
      PhLetter: begin
        letter_d = c;
        phase_d  = is_addr ? PhSpace : PhDecided;
      end
      PhSpace: begin
        if (c == nacp_pkg::ChSpace) begin
          win_d   = '0;
          phase_d = PhWindow;
        end else begin
          fault_d = 1'b1;
          phase_d = PhDecided;
        end
      end
      PhWindow: begin
        if (c == nacp_pkg::ChNul) begin
          phase_d = PhClosed;
        end else begin
          if (c == delim) begin
            tcc_d = '0;
          end else begin
            if (tcc_q == 2'd0) begin
              if (tok_q != nacp_pkg::TokSat) begin
                tok_d = tok_q + 3'd1;
              end
              acc_base = '0;
              acc_d    = '0;
            end
            if (tcc_q < lim) begin
              tcc_d = tcc_q + 2'd1;
              if (is_mac) begin
                if (!is_hex) begin
                  fault_d = 1'b1;
                end
              end else if (is_dec) begin
                // acc * 10 + digit, kept to 10 bits
                acc_d = (acc_base << 3) + (acc_base << 1) + {6'd0, c[3:0]};
                if ((tok_d >= 3'd1) && (tok_d <= 3'd4)) begin
                  tb_d[2'(tok_d - 3'd1)] = acc_d[7:0];
                end
              end else begin
                fault_d = 1'b1;
              end
            end
          end
          win_d = win_q + 6'd1;
          if (win_d >= win_lim) begin
            phase_d = PhClosed;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Line outcome, decoded from the state after this byte.
  always_comb begin
    val = {tb_d[0], tb_d[1], tb_d[2], tb_d[3]};
    st  = nacp_pkg::StNoDash;
    case (phase_d)
      PhLetter: st = nacp_pkg::StUnknown;
      PhSpace:  st = nacp_pkg::StSyntaxErr;
      PhDecided: begin
        if (letter_d == nacp_pkg::ChH) begin
          st = nacp_pkg::StHelp;
        end else if (letter_d == nacp_pkg::ChP) begin
          st = nacp_pkg::StPrint;
        end else if ((letter_d == nacp_pkg::ChI) || (letter_d == nacp_pkg::ChS) ||
                     (letter_d == nacp_pkg::ChG) || (letter_d == nacp_pkg::ChM)) begin
          st = nacp_pkg::StSyntaxErr;
        end else begin
          st = nacp_pkg::StUnknown;
        end
      end
      PhWindow, PhClosed: begin
        if (letter_d == nacp_pkg::ChM) begin
          st = ((tok_d == nacp_pkg::MacTokens) && !fault_d) ?
               nacp_pkg::StMacValid : nacp_pkg::StSyntaxErr;
        end else if ((tok_d != nacp_pkg::IpTokens) || fault_d) begin
          st = nacp_pkg::StSyntaxErr;
        end else if (letter_d == nacp_pkg::ChI) begin
          st = nacp_pkg::StIpSet;
        end else if (letter_d == nacp_pkg::ChS) begin
          st = nacp_pkg::StMaskSet;
        end else begin
          st = nacp_pkg::StGwSet;
        end
      end
      default: st = nacp_pkg::StNoDash;
    endcase
  end

  assign res_valid_o         = take_i && item_i.line_end;
  assign res_o.status        = st;
  assign res_o.address_value = (st <= nacp_pkg::StGwSet) ? val : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSearch;
      letter_q <= '0;
      win_q    <= '0;
      tok_q    <= '0;
      tcc_q    <= '0;
      acc_q    <= '0;
      fault_q  <= 1'b0;
    end else if (take_i) begin
      if (item_i.line_end) begin
        phase_q  <= PhSearch;
        letter_q <= '0;
        win_q    <= '0;
        tok_q    <= '0;
        tcc_q    <= '0;
        acc_q    <= '0;
        fault_q  <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        letter_q <= letter_d;
        win_q    <= win_d;
        tok_q    <= tok_d;
        tcc_q    <= tcc_d;
        acc_q    <= acc_d;
        fault_q  <= fault_d;
      end
    end
  end

  // Token bytes: no reset, only read once written.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      for (int k = 0; k < 4; k++) begin
        tb_q[k] <= tb_d[k];
      end
    end
  end

endmodule

>>> design/nacp_outbuf.sv
// Result register with a skid entry.
`timescale 1ns / 1ps

module nacp_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nacp_pkg::out_t data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output nacp_pkg::out_t out_data_o
);

  logic           out_valid_q, skid_valid_q;
  nacp_pkg::out_t out_q, skid_q;
  logic           out_take;

  assign out_take    = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_take) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

>>> design/network_address_command_parser.sv
// Top level of the network address command parser.
// Usage:
//   Command-line bytes arrive on the input channel (in_valid_i / in_stall_o,
//   payload in_data_i), one byte per transfer; line_end marks the last byte.
//   The parser skips bytes up to the first dash, decodes the command letter
//   and, for address commands, splits the following window into tokens.
//   Exactly one result transfer leaves on the output channel (out_valid_o /
//   out_stall_i, payload out_data_o) for each line, after the byte that
//   carries line_end is taken; other bytes produce nothing.
// Data path and throughput:
//   A result is registered once its last byte is taken. One byte is
//   taken every cycle while in_stall_o is low; the per-byte logic sits
//   between the line state registers and the result register.
// Stall behavior:
//   The result register is backed by one skid entry, so bytes keep flowing
//   while a result waits. in_stall_o rises only when both entries hold
//   results, and drops the cycle after the receiver takes one.
// Reset:
//   rst_ni clears the line state to "searching for dash" and empties the
//   result register and skid entry.
`timescale 1ns / 1ps

module network_address_command_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nacp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output nacp_pkg::out_t out_data_o
);

  logic           take;
  logic           res_valid;
  nacp_pkg::out_t res;
  logic           full;

  // byte transfer on the input channel
  assign take       = in_valid_i && !full;
  assign in_stall_o = full;

  nacp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  nacp_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .data_i     (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // the skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry full while result register empty");

  // after a line end is taken, a result is always valid in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.line_end) |=> out_valid_o)
    else $error("line end taken without result");

  // only set commands carry an address
  a_value_only_on_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.address_value != 32'd0)) |->
    (out_data_o.status <= nacp_pkg::StGwSet))
    else $error("address value on a non-set status");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= nacp_pkg::StNoDash))
    else $error("status code out of range");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the network address command parser.
`timescale 1ns / 1ps

module testbench;

  // Progress through one command line, as the checker tracks it.
  typedef enum logic [2:0] {
    SeekDash, TakeLetter, TakeSpace, InWindow, WindowShut, CmdDone, NulBeforeDash
  } line_phase_e;

  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowQ = 8'h71;
  localparam int unsigned PhaseBytes = 350;

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  nacp_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  nacp_pkg::out_t out_data;

  network_address_command_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  nacp_pkg::in_t  pending_bytes[$];
  nacp_pkg::out_t expected_results[$];
  logic [7:0]     line_buf[$];
  int unsigned queued_bytes   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned mismatch_count = 0;

  // Line parser shadow state.
  line_phase_e line_phase  = SeekDash;
  logic [7:0]  cmd_char    = '0;
  int unsigned win_count   = 0;
  int unsigned tok_count   = 0;
  int unsigned tok_len     = 0;
  logic [9:0]  acc         = '0;
  logic [7:0]  byte_field[4] = '{default: '0};
  logic        bad_syntax  = 1'b0;
  logic [31:0] stored_addr[3] = '{default: '0};  // gateway, mask, ip

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic bit is_addr_letter(logic [7:0] c);
    return c == nacp_pkg::ChI || c == nacp_pkg::ChS ||
           c == nacp_pkg::ChG || c == nacp_pkg::ChM;
  endfunction

  function automatic void clear_line();
    line_phase = SeekDash;
    cmd_char   = '0;
    win_count  = 0;
    tok_count  = 0;
    tok_len    = 0;
    acc        = '0;
    bad_syntax = 1'b0;
  endfunction

  // Tokenizer for one byte inside the address window.
  function automatic void take_window_byte(logic [7:0] c);
    bit          mac;
    logic [7:0]  sep;
    int unsigned lim;
    bit          dec;
    mac = (cmd_char == nacp_pkg::ChM);
    sep = mac ? nacp_pkg::ChColon : nacp_pkg::ChDot;
    lim = mac ? nacp_pkg::MacTokLimit : nacp_pkg::IpTokLimit;
    dec = (c >= nacp_pkg::Ch0 && c <= nacp_pkg::Ch9);
    if (c == sep) begin
      tok_len = 0;
      return;
    end
    if (tok_len == 0) begin
      if (tok_count < nacp_pkg::TokSat) tok_count++;
      acc = '0;
    end
    if (tok_len < lim) begin
      tok_len++;
      if (mac) begin
        if (!(dec || (c >= nacp_pkg::ChUpA && c <= nacp_pkg::ChUpF))) bad_syntax = 1'b1;
      end else if (dec) begin
        acc = 10'(acc * 10 + (c - nacp_pkg::Ch0));
        if (tok_count >= 1 && tok_count <= 4) byte_field[tok_count - 1] = acc[7:0];
      end else begin
        bad_syntax = 1'b1;
      end
    end
  endfunction

  function automatic nacp_pkg::out_t line_result();
    nacp_pkg::out_t r;
    logic [31:0]    v;
    r.status        = nacp_pkg::StNoDash;
    r.address_value = '0;
    case (line_phase)
      TakeLetter: r.status = nacp_pkg::StUnknown;
      TakeSpace:  r.status = nacp_pkg::StSyntaxErr;
      CmdDone: begin
        if (cmd_char == nacp_pkg::ChH) r.status = nacp_pkg::StHelp;
        else if (cmd_char == nacp_pkg::ChP) r.status = nacp_pkg::StPrint;
        else if (is_addr_letter(cmd_char)) r.status = nacp_pkg::StSyntaxErr;
        else r.status = nacp_pkg::StUnknown;
      end
      InWindow, WindowShut: begin
        if (cmd_char == nacp_pkg::ChM) begin
          r.status = (tok_count == nacp_pkg::MacTokens && !bad_syntax) ?
                     nacp_pkg::StMacValid : nacp_pkg::StSyntaxErr;
        end else if (tok_count != nacp_pkg::IpTokens || bad_syntax) begin
          r.status = nacp_pkg::StSyntaxErr;
        end else begin
          v = {byte_field[0], byte_field[1], byte_field[2], byte_field[3]};
          r.status = (cmd_char == nacp_pkg::ChI) ? nacp_pkg::StIpSet :
                     (cmd_char == nacp_pkg::ChS) ? nacp_pkg::StMaskSet :
                     nacp_pkg::StGwSet;
          stored_addr[2 - int'(r.status)] = v;
          r.address_value = v;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Advance the shadow parser by one accepted byte; a line end yields one result.
  function automatic void absorb_byte(nacp_pkg::in_t b);
    logic [7:0] c;
    c = b.character;
    case (line_phase)
      SeekDash: begin
        if (c == nacp_pkg::ChDash) line_phase = TakeLetter;
        else if (c == nacp_pkg::ChNul) line_phase = NulBeforeDash;
      end
      TakeLetter: begin
        cmd_char   = c;
        line_phase = is_addr_letter(c) ? TakeSpace : CmdDone;
      end
      TakeSpace: begin
        if (c == nacp_pkg::ChSpace) begin
          win_count  = 0;
          line_phase = InWindow;
        end else begin
          bad_syntax = 1'b1;
          line_phase = CmdDone;
        end
      end
      InWindow: begin
        if (c == nacp_pkg::ChNul) begin
          line_phase = WindowShut;
        end else begin
          take_window_byte(c);
          win_count++;
          if (win_count >= ((cmd_char == nacp_pkg::ChM) ? nacp_pkg::MacWindow :
                                                          nacp_pkg::IpWindow))
            line_phase = WindowShut;
        end
      end
      default: ;
    endcase
    if (b.line_end) begin
      expected_results.push_back(line_result());
      clear_line();
    end
  endfunction

  // Sender: holds a stalled transfer, otherwise draws the next byte or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_byte(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin : result_check
    nacp_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: status %0d address %h",
                                out_data.status, out_data.address_value));
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
        if (out_data.address_value !== want.address_value)
          flag_mismatch($sformatf("address %h, expected %h",
                                  out_data.address_value, want.address_value));
      end
    end
  end

  // ---- line builders ----

  function automatic void send_line();
    nacp_pkg::in_t b;
    foreach (line_buf[k]) begin
      b.character = line_buf[k];
      b.line_end  = (k == line_buf.size() - 1);
      pending_bytes.push_back(b);
    end
    queued_bytes += line_buf.size();
    line_buf.delete();
  endfunction

  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(255));
  endfunction

  // Any byte that neither starts a command nor ends the text.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(254, 1));
    if (c >= nacp_pkg::ChDash) c++;
    return c;
  endfunction

  function automatic void add_prefix();
    repeat ($urandom_range(2)) line_buf.push_back(junk_char());
  endfunction

  function automatic void add_tail();
    case ($urandom_range(5))
      0: repeat ($urandom_range(12, 1)) line_buf.push_back(any_char());
      1: begin
        line_buf.push_back(nacp_pkg::ChNul);
        repeat ($urandom_range(3)) line_buf.push_back(any_char());
      end
      default: ;
    endcase
  endfunction

  function automatic void add_number();
    case ($urandom_range(7))
      0: add_text("0");
      1: add_text("255");
      2: add_text("256");
      3: add_text("999");
      4: add_text($sformatf("%03d", $urandom_range(999)));
      5: add_text($sformatf("%0d", $urandom_range(99999, 1000)));  // over-long token
      default: add_text($sformatf("%0d", $urandom_range(255)));
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned n;
    n = $urandom_range(15);
    if ($urandom_range(29) == 0) return 8'(ChLowA + $urandom_range(5));
    return (n < 10) ? 8'(nacp_pkg::Ch0 + n) : 8'(nacp_pkg::ChUpA + n - 10);
  endfunction

  function automatic void build_ip_line();
    int unsigned ntok;
    line_buf.push_back(nacp_pkg::ChDash);
    case ($urandom_range(2))
      0: line_buf.push_back(nacp_pkg::ChI);
      1: line_buf.push_back(nacp_pkg::ChS);
      default: line_buf.push_back(nacp_pkg::ChG);
    endcase
    ntok = ($urandom_range(9) == 0) ? $urandom_range(6, 1) : 4;
    line_buf.push_back(nacp_pkg::ChSpace);
    if ($urandom_range(7) == 0) line_buf.push_back(nacp_pkg::ChDot);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat (($urandom_range(7) == 0) ? $urandom_range(4, 2) : 1)
        line_buf.push_back(nacp_pkg::ChDot);
      add_number();
    end
  endfunction

  function automatic void build_mac_line();
    int unsigned ntok;
    ntok = ($urandom_range(7) == 0) ? $urandom_range(8, 4) : 6;
    line_buf.push_back(nacp_pkg::ChDash);
    line_buf.push_back(nacp_pkg::ChM);
    line_buf.push_back(nacp_pkg::ChSpace);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat (($urandom_range(9) == 0) ? 2 : 1)
        line_buf.push_back(nacp_pkg::ChColon);
      repeat (($urandom_range(9) == 0) ? $urandom_range(3, 1) : 2)
        line_buf.push_back(hex_char());
    end
  endfunction

  // Mostly address lines; the rest short commands, broken lines and noise.
  function automatic void queue_random_lines(int unsigned budget);
    int unsigned target;
    int unsigned pick;
    int unsigned pos;
    target = queued_bytes + budget;
    while (queued_bytes < target) begin
      pick = $urandom_range(99);
      add_prefix();
      if (pick < 32) begin
        build_ip_line();
        add_tail();
      end else if (pick < 54) begin
        build_mac_line();
        add_tail();
      end else if (pick < 66) begin
        line_buf.push_back(nacp_pkg::ChDash);
        case ($urandom_range(3))
          0: line_buf.push_back(nacp_pkg::ChH);
          1: line_buf.push_back(nacp_pkg::ChP);
          2: line_buf.push_back(ChLowQ);
          default: line_buf.push_back(any_char());
        endcase
        add_tail();
      end else if (pick < 86) begin
        if (pick[0]) build_ip_line();
        else build_mac_line();
        pos = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(2))
          0: line_buf[pos] = any_char();
          1: line_buf.insert(pos, nacp_pkg::ChNul);
          default: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
        endcase
      end else begin
        repeat ($urandom_range(20, 1))
          line_buf.push_back(($urandom_range(5) == 0) ? nacp_pkg::ChDash : any_char());
      end
      send_line();
    end
  endfunction

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short directed lines: control bytes and truncated commands.
    line_buf.push_back(8'hFF);                            // no dash at all
    send_line();
    add_text("a");                                        // nul before the dash
    line_buf.push_back(nacp_pkg::ChNul);
    add_text("-h");
    send_line();
    line_buf.push_back(nacp_pkg::ChDash);                 // ends right after dash
    send_line();
    line_buf.push_back(nacp_pkg::ChDash);                 // nul as the letter
    line_buf.push_back(nacp_pkg::ChNul);
    send_line();
    add_text("-h");
    send_line();
    add_text("-p");
    send_line();
    add_text("-i");                                       // ends after the letter
    send_line();
    add_text("-s");                                       // nul in place of space
    line_buf.push_back(nacp_pkg::ChNul);
    send_line();
    add_text("-gx");                                      // missing space
    send_line();
    add_text("-q");                                       // unknown letter
    send_line();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      queue_random_lines(PhaseBytes);
      while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
        @(posedge clk_i);
    end

    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    flag_mismatch("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
design/nacp_pkg.sv
design/nacp_parse.sv
design/nacp_outbuf.sv
design/network_address_command_parser.sv
dv/testbench.sv
